// ===== src/msds_pkg.sv =====
// ----------------------------------------------------------------------------
// msds_pkg: shared types and constants for the scanout descriptor sequencer
// Holds the descriptor kind codes, register indexes and the structs that move
// between the row table, the step logic and the top level.
// ----------------------------------------------------------------------------
package msds_pkg;

	// Default geometry
	localparam int unsigned ACTIVE_LINES_DEF  = 480;
	localparam int unsigned CONTENT_WIDTH_DEF = 480;
	localparam int unsigned SOURCE_ROWS_DEF   = 240;
	localparam int unsigned SIDE_BORDER_DEF   = 80;

	// Words in a blank-line command list
	localparam logic [7:0] VBLANK_WORDS = 8'd7;

	// Configuration register indexes
	typedef logic [1:0] cfg_index_t;
	localparam cfg_index_t REG_V_FRONT_PORCH = 2'd0;
	localparam cfg_index_t REG_V_SYNC_LINES  = 2'd1;
	localparam cfg_index_t REG_V_BACK_PORCH  = 2'd2;

	typedef enum logic [2:0] {
		KIND_VBLANK      = 3'd0,
		KIND_VSYNC       = 3'd1,
		KIND_ACTIVE_CMDS = 3'd2,
		KIND_BLACK_FILL  = 3'd3,
		KIND_PIXELS      = 3'd4
	} kind_t;

	typedef struct packed {
		logic [5:0] v_front_porch;
		logic [3:0] v_sync_lines;
		logic [6:0] v_back_porch;
	} cfg_t;

	// Precomputed per-row geometry, already masked to output widths
	typedef struct packed {
		logic [7:0] fill_words;
		logic [7:0] span_words;
		logic [6:0] span_offset;
		logic [7:0] source_row;
	} row_info_t;

	typedef struct packed {
		logic       channel;
		kind_t      kind;
		logic [7:0] word_count;
		logic [7:0] pixel_row;
		logic [6:0] pixel_word_offset;
	} desc_t;

endpackage

// ===== src/msds_row_rom.sv =====
// ----------------------------------------------------------------------------
// msds_row_rom: per-row mask geometry table with registered read
// Builds the circle half-width table at elaboration (folded about the middle
// row) and the source row table, and registers one lookup.
// ----------------------------------------------------------------------------
module msds_row_rom #(
	parameter int unsigned ACTIVE_LINES  = msds_pkg::ACTIVE_LINES_DEF,
	parameter int unsigned CONTENT_WIDTH = msds_pkg::CONTENT_WIDTH_DEF,
	parameter int unsigned SOURCE_ROWS   = msds_pkg::SOURCE_ROWS_DEF,
	parameter int unsigned SIDE_BORDER   = msds_pkg::SIDE_BORDER_DEF
) (
	input  logic                            clk,
	input  logic [$clog2(ACTIVE_LINES)-1:0] row,
	output msds_pkg::row_info_t             info
);

	localparam int unsigned RW   = $clog2(ACTIVE_LINES);
	localparam int unsigned FOLD = (ACTIVE_LINES + 1) / 2;
	localparam int unsigned FW   = (FOLD > 1) ? $clog2(FOLD) : 1;
	localparam logic [RW-1:0] LAST_ROW = RW'(ACTIVE_LINES - 1);
	localparam logic [RW-1:0] FOLD_ROW = RW'(FOLD);

	function automatic int unsigned isqrt(input int unsigned x);
		int unsigned res;
		int unsigned bitv;
		int unsigned rem;
		res  = 0;
		bitv = 32'h4000_0000;
		rem  = x;
		while (bitv > rem)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Visible half-width of a row, rounded down to even, clamped to half content
	function automatic int unsigned circle_half(input int unsigned r);
		int unsigned span;
		int unsigned twice;
		int unsigned ad;
		int unsigned h;
		span  = ACTIVE_LINES - 1;
		twice = 2 * r;
		ad    = (twice >= span) ? (twice - span) : (span - twice);
		h     = 0;
		if (ad < CONTENT_WIDTH)
			h = (isqrt(CONTENT_WIDTH * CONTENT_WIDTH - ad * ad) + 1) >> 1;
		h = h & ~32'd1;
		if (h > (CONTENT_WIDTH >> 1))
			h = CONTENT_WIDTH >> 1;
		return h;
	endfunction

	typedef struct packed {
		logic [7:0] fill_words;
		logic [7:0] span_words;
		logic [6:0] span_offset;
	} shape_t;

	shape_t     shape_tab [FOLD];
	logic [7:0] srow_tab  [FOLD];

	for (genvar g = 0; g < FOLD; g++) begin : g_tab
		localparam int unsigned H    = circle_half(g);
		localparam int unsigned CUT  = CONTENT_WIDTH / 2 - H;
		localparam int unsigned FILL = (SIDE_BORDER + CUT) / 2;
		// Entry g of the source row table serves active rows 2g and 2g+1
		localparam int unsigned SROW = g % SOURCE_ROWS;
		assign shape_tab[g] = '{fill_words: 8'(FILL), span_words: 8'(H),
			span_offset: 7'(CUT / 2)};
		assign srow_tab[g] = 8'(SROW);
	end

	logic [RW-1:0] fold_row;
	logic [RW-1:0] half_row;
	shape_t        shape;

	assign fold_row = (row < FOLD_ROW) ? row : (LAST_ROW - row);
	assign half_row = row >> 1;
	assign shape    = shape_tab[fold_row[FW-1:0]];

	always_ff @(posedge clk) begin
		info.fill_words  <= shape.fill_words;
		info.span_words  <= shape.span_words;
		info.span_offset <= shape.span_offset;
		info.source_row  <= srow_tab[half_row[FW-1:0]];
	end

endmodule

// ===== src/msds_step.sv =====
// ----------------------------------------------------------------------------
// msds_step: descriptor decode and next line/phase
// Classifies the current scanline, builds the descriptor for one event and
// works out the line counter and row phase that follow it.
// ----------------------------------------------------------------------------
module msds_step #(
	parameter int unsigned ACTIVE_LINES = msds_pkg::ACTIVE_LINES_DEF
) (
	input  logic [$clog2(ACTIVE_LINES+206)-1:0] line_q,
	input  logic [1:0]                          phase_q,
	input  logic                                pong_q,
	input  msds_pkg::cfg_t                      cfg,
	input  msds_pkg::row_info_t                 info,
	output msds_pkg::desc_t                     desc,
	output logic [$clog2(ACTIVE_LINES+206)-1:0] line_nxt,
	output logic [1:0]                          phase_nxt
);

	localparam int unsigned LW = $clog2(ACTIVE_LINES + 206);

	localparam logic [1:0] PHASE_CMDS  = 2'd0;
	localparam logic [1:0] PHASE_LEFT  = 2'd1;
	localparam logic [1:0] PHASE_SPAN  = 2'd2;
	localparam logic [1:0] PHASE_RIGHT = 2'd3;

	localparam logic [7:0] ACTIVE_CMD_WORDS = 8'd9;

	logic [7:0]    blank;
	logic [6:0]    sync_end;
	logic [LW-1:0] total;
	logic [LW-1:0] line;
	logic [LW-1:0] line_inc;
	logic [LW-1:0] line_wrap;
	logic          advance;

	assign blank    = 8'(cfg.v_front_porch) + 8'(cfg.v_sync_lines) + 8'(cfg.v_back_porch);
	assign sync_end = 7'(cfg.v_front_porch) + 7'(cfg.v_sync_lines);
	assign total    = LW'(blank) + LW'(ACTIVE_LINES);
	// Treat a line left past the frame by a register write as line 0
	assign line      = (line_q < total) ? line_q : '0;
	assign line_inc  = line + LW'(1);
	assign line_wrap = (line_inc >= total) ? '0 : line_inc;

	always_comb begin
		desc.channel           = pong_q;
		desc.kind              = msds_pkg::KIND_VBLANK;
		desc.word_count        = msds_pkg::VBLANK_WORDS;
		desc.pixel_row         = '0;
		desc.pixel_word_offset = '0;
		phase_nxt              = phase_q;
		advance                = 1'b1;
		priority if (line >= LW'(cfg.v_front_porch) && line < LW'(sync_end)) begin
			desc.kind = msds_pkg::KIND_VSYNC;
		end else if (line < LW'(blank)) begin
			desc.kind = msds_pkg::KIND_VBLANK;
		end else begin
			advance = 1'b0;
			unique case (phase_q)
				PHASE_CMDS: begin
					desc.kind       = msds_pkg::KIND_ACTIVE_CMDS;
					desc.word_count = ACTIVE_CMD_WORDS;
					phase_nxt       = PHASE_LEFT;
				end
				PHASE_LEFT: begin
					desc.kind       = msds_pkg::KIND_BLACK_FILL;
					desc.word_count = info.fill_words;
					phase_nxt       = PHASE_SPAN;
				end
				PHASE_SPAN: begin
					desc.kind              = msds_pkg::KIND_PIXELS;
					desc.word_count        = info.span_words;
					desc.pixel_row         = info.source_row;
					desc.pixel_word_offset = info.span_offset;
					phase_nxt              = PHASE_RIGHT;
				end
				PHASE_RIGHT: begin
					desc.kind       = msds_pkg::KIND_BLACK_FILL;
					desc.word_count = info.fill_words;
					phase_nxt       = PHASE_CMDS;
					advance         = 1'b1;
				end
				default: begin
					phase_nxt = PHASE_CMDS;
				end
			endcase
		end
		line_nxt = advance ? line_wrap : line;
	end

endmodule

// ===== src/masked_scanout_descriptor_sequencer.sv =====
// ----------------------------------------------------------------------------
// masked_scanout_descriptor_sequencer: scanout descriptor sequencer, circle mask
// Takes one transaction per clock on the input channel while in_stall is low.
// Each transaction with transfer_done set yields exactly one descriptor on the
// output channel, registered in the output register or, when that register is
// held, in the skid register; a transaction with transfer_done clear is consumed
// and yields nothing. The sustained rate is one transaction per cycle while the
// receiver does not stall: the line counter, row phase and channel bit update
// in one registered step, and the per-row mask geometry is looked up from the
// state the next edge will hold and registered, so it is always ready when the
// next event arrives. A two-entry output stage (output register plus skid
// register) lets a new event enter while an earlier descriptor is still held
// by a stalled receiver; in_stall rises only when both entries are full. The
// configuration port is always ready and must be written only while the block
// is idle. The geometry tables are constants: no clearing pass after reset.
// ----------------------------------------------------------------------------
module masked_scanout_descriptor_sequencer #(
	parameter int unsigned ACTIVE_LINES  = msds_pkg::ACTIVE_LINES_DEF,
	parameter int unsigned CONTENT_WIDTH = msds_pkg::CONTENT_WIDTH_DEF,
	parameter int unsigned SOURCE_ROWS   = msds_pkg::SOURCE_ROWS_DEF,
	parameter int unsigned SIDE_BORDER   = msds_pkg::SIDE_BORDER_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	// event input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       transfer_done,
	// descriptor output channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic       channel,
	output logic [2:0] kind,
	output logic [7:0] word_count,
	output logic [7:0] pixel_row,
	output logic [6:0] pixel_word_offset,
	// configuration write channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [6:0] cfg_data
);

	localparam int unsigned LW = $clog2(ACTIVE_LINES + 206);
	localparam int unsigned RW = $clog2(ACTIVE_LINES);

	localparam logic [5:0] V_FRONT_PORCH_RST = 6'd10;
	localparam logic [3:0] V_SYNC_LINES_RST  = 4'd2;
	localparam logic [6:0] V_BACK_PORCH_RST  = 7'd33;
	localparam logic [LW-1:0] LINE_RST       = LW'(2);

	// Architectural state
	logic [LW-1:0]   line_q;
	logic [1:0]      phase_q;
	logic            pong_q;
	msds_pkg::cfg_t  cfg_q;

	// Output stage
	logic            out_valid_q;
	msds_pkg::desc_t out_q;
	logic            skid_valid_q;
	msds_pkg::desc_t skid_q;

	msds_pkg::row_info_t info;
	msds_pkg::desc_t     desc;
	logic [LW-1:0]       line_nxt;
	logic [1:0]          phase_nxt;

	logic                event_acc;
	logic                out_take;
	msds_pkg::cfg_t      cfg_n;
	logic [LW-1:0]       line_n;
	logic [7:0]          blank_n;
	logic [LW-1:0]       total_n;
	logic [LW-1:0]       eff_n;
	logic [RW-1:0]       row_addr;

	assign in_stall  = skid_valid_q;
	assign cfg_ready = 1'b1;
	assign event_acc = in_valid && !skid_valid_q && transfer_done;
	assign out_take  = out_valid_q && !out_stall;

	msds_step #(
		.ACTIVE_LINES(ACTIVE_LINES)
	) u_step (
		.line_q   (line_q),
		.phase_q  (phase_q),
		.pong_q   (pong_q),
		.cfg      (cfg_q),
		.info     (info),
		.desc     (desc),
		.line_nxt (line_nxt),
		.phase_nxt(phase_nxt)
	);

	// Next configuration: apply a write this cycle
	always_comb begin
		cfg_n = cfg_q;
		if (cfg_valid) begin
			unique case (cfg_index)
				msds_pkg::REG_V_FRONT_PORCH: cfg_n.v_front_porch = cfg_data[5:0];
				msds_pkg::REG_V_SYNC_LINES:  cfg_n.v_sync_lines  = cfg_data[3:0];
				msds_pkg::REG_V_BACK_PORCH:  cfg_n.v_back_porch  = cfg_data;
				default: ;
			endcase
		end
	end

	// Look up the row the state will hold after this edge, so the table
	// register always matches line_q and cfg_q
	assign line_n  = event_acc ? line_nxt : line_q;
	assign blank_n = 8'(cfg_n.v_front_porch) + 8'(cfg_n.v_sync_lines)
		+ 8'(cfg_n.v_back_porch);
	assign total_n = LW'(blank_n) + LW'(ACTIVE_LINES);
	assign eff_n   = (line_n < total_n) ? line_n : '0;
	// Park the address at row 0 on blank lines
	assign row_addr = (eff_n >= LW'(blank_n)) ? RW'(eff_n - LW'(blank_n)) : '0;

	msds_row_rom #(
		.ACTIVE_LINES (ACTIVE_LINES),
		.CONTENT_WIDTH(CONTENT_WIDTH),
		.SOURCE_ROWS  (SOURCE_ROWS),
		.SIDE_BORDER  (SIDE_BORDER)
	) u_row_rom (
		.clk (clk),
		.row (row_addr),
		.info(info)
	);

	// Advance line, phase and channel on each event; hold otherwise
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q  <= LINE_RST;
			phase_q <= '0;
			pong_q  <= 1'b0;
			cfg_q   <= '{v_front_porch: V_FRONT_PORCH_RST,
				v_sync_lines: V_SYNC_LINES_RST, v_back_porch: V_BACK_PORCH_RST};
		end else begin
			cfg_q <= cfg_n;
			if (event_acc) begin
				line_q  <= line_nxt;
				phase_q <= phase_nxt;
				pong_q  <= ~pong_q;
			end
		end
	end

	// Output stage control: refill the output register from the skid entry
	// first, then from a new event; park a new event in the skid entry when
	// the output register is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_take || !out_valid_q) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= event_acc;
				end
			end else if (event_acc) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_take || !out_valid_q) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (event_acc) begin
				out_q <= desc;
			end
		end else if (event_acc) begin
			skid_q <= desc;
		end
	end

	assign out_valid         = out_valid_q;
	assign channel           = out_q.channel;
	assign kind              = out_q.kind;
	assign word_count        = out_q.word_count;
	assign pixel_row         = out_q.pixel_row;
	assign pixel_word_offset = out_q.pixel_word_offset;

endmodule

// ===== src/msds_checker.sv =====
// ----------------------------------------------------------------------------
// msds_checker: port-level checks for the scanout descriptor sequencer
// Watches the top-level ports and flags descriptor and handshake slips.
// ----------------------------------------------------------------------------
module msds_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       channel,
	input logic [2:0] kind,
	input logic [7:0] word_count,
	input logic [7:0] pixel_row,
	input logic [6:0] pixel_word_offset
);

	logic exp_channel_q;

	// Track the channel the next delivered descriptor must carry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_channel_q <= 1'b0;
		end else if (out_valid && !out_stall) begin
			exp_channel_q <= ~exp_channel_q;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(channel) && $stable(kind)
			&& $stable(word_count) && $stable(pixel_row) && $stable(pixel_word_offset))
		else $error("stalled descriptor changed");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");

	a_channel_alt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> channel == exp_channel_q)
		else $error("channel did not alternate");

	a_non_pixel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != msds_pkg::KIND_PIXELS |-> pixel_row == 8'd0
			&& pixel_word_offset == 7'd0)
		else $error("non-pixel descriptor carries a source position");

	a_vblank_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == msds_pkg::KIND_VBLANK || kind == msds_pkg::KIND_VSYNC)
			|-> word_count == msds_pkg::VBLANK_WORDS)
		else $error("blank line descriptor has wrong length");

endmodule

bind masked_scanout_descriptor_sequencer msds_checker u_msds_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_stall         (in_stall),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.channel          (channel),
	.kind             (kind),
	.word_count       (word_count),
	.pixel_row        (pixel_row),
	.pixel_word_offset(pixel_word_offset)
);
